/* design/gbcr_pkg.sv */
// gbcr_pkg: shared types and helpers for the gf2 boundary column reduction block
`timescale 1ns / 1ps

package gbcr_pkg;

  // control from the sequencer into the pivot table
  typedef struct packed {
    logic clear;   // drop every claim
    logic claim;   // claim wr_row for wr_owner
  } ptab_ctrl_t;

  // highest set bit of a 64-bit mask, 0 when the mask is empty
  function automatic logic [5:0] top_row(input logic [63:0] m);
    logic [63:0] v;
    logic [5:0]  r;
    v = m;
    r = 6'd0;
    if (|v[63:32]) begin
      r[5] = 1'b1;
      v = {32'd0, v[63:32]};
    end
    if (|v[31:16]) begin
      r[4] = 1'b1;
      v = {48'd0, v[31:16]};
    end
    if (|v[15:8]) begin
      r[3] = 1'b1;
      v = {56'd0, v[15:8]};
    end
    if (|v[7:4]) begin
      r[2] = 1'b1;
      v = {60'd0, v[7:4]};
    end
    if (|v[3:2]) begin
      r[1] = 1'b1;
      v = {62'd0, v[3:2]};
    end
    if (v[1]) begin
      r[0] = 1'b1;
    end
    return r;
  endfunction

endpackage

/* design/gbcr_col_store.sv */
// gbcr_col_store: reduced column memory, one write and one registered read port
`timescale 1ns / 1ps

module gbcr_col_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* design/gbcr_pivot_table.sv */
// gbcr_pivot_table: pivot owner memory with per-row claim flags
`timescale 1ns / 1ps

module gbcr_pivot_table #(
  parameter int ROWS = 64,
  parameter int RW   = 6,
  parameter int OW   = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gbcr_pkg::ptab_ctrl_t ctrl,
  input  logic [RW-1:0]        rd_row,
  input  logic [RW-1:0]        wr_row,
  input  logic [OW-1:0]        wr_owner,
  output logic                 rd_claimed,
  output logic [OW-1:0]        rd_owner
);

  logic [OW-1:0]   owner_mem [ROWS];
  logic [ROWS-1:0] claimed_r;
  logic [ROWS-1:0] claimed_nxt;
  logic            rd_claimed_r;
  logic [OW-1:0]   rd_owner_r;

  always_comb begin
    claimed_nxt = claimed_r;
    if (ctrl.clear) begin
      claimed_nxt = '0;
    end else if (ctrl.claim) begin
      claimed_nxt[wr_row] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      claimed_r    <= '0;
      rd_claimed_r <= 1'b0;
    end else begin
      claimed_r    <= claimed_nxt;
      rd_claimed_r <= claimed_r[rd_row];
    end
  end

  // owner entries are only trusted behind a claim flag
  always_ff @(posedge clk) begin
    if (ctrl.claim && !ctrl.clear) begin
      owner_mem[wr_row] <= wr_owner;
    end
    rd_owner_r <= owner_mem[rd_row];
  end

  assign rd_claimed = rd_claimed_r;
  assign rd_owner   = rd_owner_r;

endmodule

/* design/gf2_boundary_column_reduction.sv */
// gf2_boundary_column_reduction: top level, reduction sequencer and result register
//
//  channel | ports                                     | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid in_ready in_column_mask in_restart | into block
//  out     | out_valid out_ready out_reduced_mask        | out of block
//          | out_pivot_row out_is_empty                  |
//          | out_column_index out_store_full             |
//
// one column is in work at a time; a column goes from transfer to result through k
// xor steps, k being at most the number of claimed rows
// each xor step is pivot lookup with owner table read, column memory read, xor:
// both memories have registered reads and the step waits on each
// a full store gives its result with no xor step; restart clears the claim flags at once
// reset is synchronous and active low; a stalled result holds only the finish step,
// the next column is taken while the result waits
`timescale 1ns / 1ps

module gf2_boundary_column_reduction #(
  parameter int ROWS = 64,
  parameter int COLS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_column_mask,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_reduced_mask,
  output logic [5:0]  out_pivot_row,
  output logic        out_is_empty,
  output logic [5:0]  out_column_index,
  output logic        out_store_full
);

  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int OW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int CW = $clog2(COLS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOOK  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_XOR   = 3'd3;
  localparam logic [2:0] ST_FULL  = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [ROWS-1:0] m_r, m_nxt;
  logic [RW-1:0]   p_r, p_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [63:0]     out_mask_r, out_mask_nxt;
  logic [5:0]      out_pivot_r, out_pivot_nxt;
  logic            out_empty_r, out_empty_nxt;
  logic [5:0]      out_index_r, out_index_nxt;
  logic            out_full_r, out_full_nxt;

  gbcr_pkg::ptab_ctrl_t ptab_ctrl;
  logic [RW-1:0]   look_row;
  logic            rd_claimed;
  logic [OW-1:0]   rd_owner;
  logic            col_we;
  logic [ROWS-1:0] col_rdata;
  logic [5:0]      top6;
  logic [63:0]     count_ext;
  logic [63:0]     pivot_ext;
  logic            slot_free;
  logic            in_xfer;
  logic            m_nonzero;

  assign top6      = gbcr_pkg::top_row(64'(m_r));
  assign look_row  = top6[RW-1:0];
  assign count_ext = 64'(count_r);
  assign pivot_ext = 64'(p_r);
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign m_nonzero = |m_r;

  gbcr_pivot_table #(
    .ROWS(ROWS),
    .RW  (RW),
    .OW  (OW)
  ) u_ptab (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ptab_ctrl),
    .rd_row    (look_row),
    .wr_row    (p_r),
    .wr_owner  (count_r[OW-1:0]),
    .rd_claimed(rd_claimed),
    .rd_owner  (rd_owner)
  );

  gbcr_col_store #(
    .DEPTH(COLS),
    .WIDTH(ROWS),
    .AW   (OW)
  ) u_cols (
    .clk  (clk),
    .we   (col_we),
    .waddr(count_r[OW-1:0]),
    .wdata(m_r),
    .raddr(rd_owner),
    .rdata(col_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    m_nxt          = m_r;
    p_nxt          = p_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_mask_nxt   = out_mask_r;
    out_pivot_nxt  = out_pivot_r;
    out_empty_nxt  = out_empty_r;
    out_index_nxt  = out_index_r;
    out_full_nxt   = out_full_r;
    ptab_ctrl      = '0;
    col_we         = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          m_nxt = in_column_mask[ROWS-1:0];
          if (in_restart) begin
            ptab_ctrl.clear = 1'b1;
            count_nxt       = '0;
            state_nxt       = ST_LOOK;
          end else if (count_r == CW'(COLS)) begin
            state_nxt = ST_FULL;
          end else begin
            state_nxt = ST_LOOK;
          end
        end
      end
      ST_LOOK: begin
        // owner table is read at look_row this cycle
        p_nxt     = look_row;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (m_nonzero && rd_claimed) begin
          // column memory is read at rd_owner this cycle
          state_nxt = ST_XOR;
        end else if (slot_free) begin
          col_we          = 1'b1;
          ptab_ctrl.claim = m_nonzero;
          out_valid_nxt   = 1'b1;
          out_mask_nxt    = 64'(m_r);
          out_pivot_nxt   = m_nonzero ? pivot_ext[5:0] : 6'd0;
          out_empty_nxt   = !m_nonzero;
          out_index_nxt   = count_ext[5:0];
          out_full_nxt    = 1'b0;
          count_nxt       = count_r + CW'(1);
          state_nxt       = ST_IDLE;
        end
      end
      ST_XOR: begin
        m_nxt     = m_r ^ col_rdata;
        state_nxt = ST_LOOK;
      end
      ST_FULL: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_mask_nxt  = 64'd0;
          out_pivot_nxt = 6'd0;
          out_empty_nxt = 1'b0;
          out_index_nxt = count_ext[5:0];
          out_full_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r         <= m_nxt;
    p_r         <= p_nxt;
    out_mask_r  <= out_mask_nxt;
    out_pivot_r <= out_pivot_nxt;
    out_empty_r <= out_empty_nxt;
    out_index_r <= out_index_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_reduced_mask = out_mask_r;
  assign out_pivot_row    = out_pivot_r;
  assign out_is_empty     = out_empty_r;
  assign out_column_index = out_index_r;
  assign out_store_full   = out_full_r;

endmodule

/* design/gbcr_checker.sv */
// gbcr_checker: port-level assertions for the reduction block, bound to the top level
`timescale 1ns / 1ps

module gbcr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_reduced_mask,
  input logic [5:0]  out_pivot_row,
  input logic        out_is_empty,
  input logic        out_store_full
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // one column in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a column is in work");

  a_full_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_full |->
      out_reduced_mask == 64'd0 && out_pivot_row == 6'd0 && !out_is_empty)
    else $error("rejected column result not cleared");

  a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_reduced_mask == 64'd0 && out_pivot_row == 6'd0)
    else $error("empty column with rows or pivot");

  // pivot is the highest set row
  a_pivot_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_empty && !out_store_full |->
      (out_reduced_mask >> out_pivot_row) == 64'd1)
    else $error("pivot is not the highest set row");

endmodule

bind gf2_boundary_column_reduction gbcr_checker u_gbcr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_reduced_mask(out_reduced_mask),
  .out_pivot_row   (out_pivot_row),
  .out_is_empty    (out_is_empty),
  .out_store_full  (out_store_full)
);

/* test/gf2_boundary_column_reduction_test.sv */
// testbench for the gf2 boundary column reduction block: queued column driver, scoreboard monitor
`timescale 1ns / 1ps

module gf2_boundary_column_reduction_test;

  localparam int ROW_COUNT      = 64;
  localparam int STORE_DEPTH    = 64;
  localparam int RANDOM_COLUMNS = 1250;
  localparam int HOLD_EVERY     = 400;
  localparam int IDLE_LIMIT     = 3000;
  localparam int SETTLE_CYCLES  = 250;
  localparam int MAX_REPORTED   = 10;

  typedef struct {
    logic [63:0] mask;
    logic        restart;
    logic        hold;     // wait for every result before this transfer
  } column_item_t;

  typedef struct packed {
    logic [63:0] mask;
    logic [5:0]  pivot;
    logic        empty;
    logic [5:0]  index;
    logic        full;
  } reduction_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_column_mask = '0;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_reduced_mask;
  logic [5:0]  out_pivot_row;
  logic        out_is_empty;
  logic [5:0]  out_column_index;
  logic        out_store_full;

  gf2_boundary_column_reduction #(
    .ROWS(ROW_COUNT),
    .COLS(STORE_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_column_mask(in_column_mask),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_reduced_mask(out_reduced_mask),
    .out_pivot_row(out_pivot_row),
    .out_is_empty(out_is_empty),
    .out_column_index(out_column_index),
    .out_store_full(out_store_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  column_item_t pending_columns[$];
  reduction_t   expected_reductions[$];
  logic [63:0]  segment_inputs[$];

  // mirror of the column store and pivot table
  logic [63:0]          reduced_store [STORE_DEPTH];
  logic [5:0]           pivot_owner_of [ROW_COUNT];
  logic [ROW_COUNT-1:0] pivot_taken = '0;
  int unsigned          store_count = 0;

  int total_columns = 0;
  int columns_in = 0;
  int results_out = 0;
  int errors = 0;
  int empty_results = 0;
  int full_results = 0;
  int xor_steps = 0;
  int deepest = 0;

  function automatic int highest_row(input logic [63:0] m);
    for (int r = 63; r > 0; r--) begin
      if (m[r]) return r;
    end
    return 0;
  endfunction

  function automatic reduction_t reduce_column(input logic [63:0] column, input logic restart);
    reduction_t  res;
    logic [63:0] m;
    int          steps;
    res = '0;
    m = column;
    steps = 0;
    if (restart) begin
      pivot_taken = '0;
      store_count = 0;
    end
    if (store_count >= STORE_DEPTH) begin
      res.full = 1'b1;
      res.index = 6'(store_count);
      full_results++;
      return res;
    end
    // clear the pivot while an earlier column owns it
    while (m != 0 && pivot_taken[highest_row(m)]) begin
      m ^= reduced_store[pivot_owner_of[highest_row(m)]];
      steps++;
    end
    reduced_store[store_count] = m;
    if (m != 0) begin
      pivot_taken[highest_row(m)] = 1'b1;
      pivot_owner_of[highest_row(m)] = 6'(store_count);
    end else begin
      empty_results++;
    end
    res.mask = m;
    res.pivot = 6'(highest_row(m));
    res.empty = (m == 0);
    res.index = 6'(store_count);
    xor_steps += steps;
    if (steps > deepest) deepest = steps;
    store_count++;
    return res;
  endfunction

  // mostly short pauses, a few long ones, now and then a calm stretch with none
  function automatic int random_pause(inout int calm);
    int pick;
    pick = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (pick < 2) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] make_column();
    logic [63:0] m;
    int          kind;
    int          t;
    int          base;
    int          n;
    kind = $urandom_range(0, 99);
    m = '0;
    if (kind < 25) begin
      m = {$urandom, $urandom};
    end else if (kind < 45) begin
      t = $urandom_range(0, 63);
      m = {$urandom, $urandom} & (~64'd0 >> (63 - t));
      m[t] = 1'b1;
    end else if (kind < 72) begin
      // boundary-like: a few rows close together, so pivots collide often
      base = $urandom_range(0, 56);
      n = $urandom_range(1, 3);
      repeat (n) m[base + $urandom_range(0, 7)] = 1'b1;
    end else if (kind < 90 && segment_inputs.size() != 0) begin
      // sum of earlier columns reduces to empty unless a row is flipped
      n = $urandom_range(1, 3);
      repeat (n) m ^= segment_inputs[$urandom_range(0, segment_inputs.size() - 1)];
      if ($urandom_range(0, 3) == 0) m[$urandom_range(0, 63)] ^= 1'b1;
    end else if (kind < 95) begin
      m[$urandom_range(0, 63)] = 1'b1;
    end
    return m;
  endfunction

  task automatic add_column(input logic [63:0] mask, input logic restart);
    column_item_t c;
    c.mask = mask;
    c.restart = restart;
    c.hold = (pending_columns.size() % HOLD_EVERY == HOLD_EVERY - 1);
    if (restart) segment_inputs.delete();
    segment_inputs.insert(segment_inputs.size(), mask);
    pending_columns.insert(pending_columns.size(), c);
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] want_v, got_v);
    errors++;
    if (errors <= MAX_REPORTED)
      $display("mismatch on result %0d, %s: expected %h, got %h",
               results_out, field, want_v, got_v);
  endtask

  // driver
  logic         in_fire = 1'b0;
  int           send_gap = 0;
  int           send_calm = 0;
  column_item_t next_col;

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_fire) begin
        // hold the column until its transfer
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_columns.size() != 0 &&
                   !(pending_columns[0].hold && expected_reductions.size() != 0)) begin
        next_col = pending_columns.pop_front();
        in_valid <= 1'b1;
        in_column_mask <= next_col.mask;
        in_restart <= next_col.restart;
        send_gap = random_pause(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  int stall_left = 0;
  int recv_calm = 0;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left = random_pause(recv_calm);
    end
  end

  // monitor and scoreboard
  reduction_t got;
  reduction_t want;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = {out_reduced_mask, out_pivot_row, out_is_empty, out_column_index, out_store_full};
      if (expected_reductions.size() == 0) begin
        note_mismatch("result with nothing outstanding", '0, got.mask);
      end else begin
        want = expected_reductions.pop_front();
        if (got.mask !== want.mask) note_mismatch("reduced_mask", want.mask, got.mask);
        if (got.pivot !== want.pivot)
          note_mismatch("pivot_row", 64'(want.pivot), 64'(got.pivot));
        if (got.empty !== want.empty)
          note_mismatch("is_empty", 64'(want.empty), 64'(got.empty));
        if (got.index !== want.index)
          note_mismatch("column_index", 64'(want.index), 64'(got.index));
        if (got.full !== want.full)
          note_mismatch("store_full", 64'(want.full), 64'(got.full));
      end
      results_out++;
    end
    in_fire = rst_n && in_valid && in_ready;
    if (in_fire) begin
      expected_reductions.insert(expected_reductions.size(),
                                 reduce_column(in_column_mask, in_restart));
      columns_in++;
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, expected_reductions.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int seg;
    int len;
    int sent;
    bit forced;

    add_column('0, 1'b1);                         // empty column straight after reset
    add_column(~64'd0, 1'b0);                     // full column claims the top row
    add_column(~64'd0, 1'b0);                     // same column cancels to empty
    add_column(64'd1, 1'b0);                      // pivot on row 0 but not empty
    add_column(64'd1, 1'b0);
    add_column(64'h8000_0000_0000_0001, 1'b0);    // top and bottom rows both owned
    add_column(64'h4000_0000_0000_0000, 1'b0);
    add_column(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    add_column(64'h5555_5555_5555_5555, 1'b0);
    add_column(64'hC000_0000_0000_0000, 1'b0);    // chain of xor steps
    add_column(~64'd0, 1'b1);                     // restart drops every claim
    add_column(64'h0000_0000_8000_0000, 1'b0);
    add_column(64'h0000_0001_0000_0000, 1'b1);    // restart again, index back to zero

    // segments that usually open with a restart; one long one always fills the store
    seg = 0;
    sent = 0;
    while (sent < RANDOM_COLUMNS) begin
      forced = (seg == 3);
      len = (forced || $urandom_range(0, 9) == 0) ? $urandom_range(66, 80)
                                                   : $urandom_range(3, 40);
      for (int i = 0; i < len; i++) begin
        if (i == 0) add_column(make_column(), forced || $urandom_range(0, 9) != 0);
        else add_column(make_column(), !forced && $urandom_range(0, 99) == 0);
      end
      sent += len;
      seg++;
    end
    total_columns = pending_columns.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (columns_in < total_columns) @(posedge clk);
    while (expected_reductions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d columns in, %0d results out: %0d reduced to empty, %0d refused on a full store",
             columns_in, results_out, empty_results, full_results);
    $display("%0d xor steps predicted, the deepest column needed %0d", xor_steps, deepest);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
